### rtl/swsfr_pkg.sv
// ----------------------------------------------------------------------------
// swsfr_pkg
// shared types and constants for the single-wire sensor frame receiver
// ----------------------------------------------------------------------------
package swsfr_pkg;

  // frame length in bits, published as five bytes
  localparam int unsigned FRAME_BITS = 40;
  localparam int unsigned BITS_W     = $clog2(FRAME_BITS + 1);
  localparam int unsigned PUB_BYTES  = 5;

  localparam int unsigned START_W  = 16;
  localparam int unsigned THRESH_W = 8;
  localparam int unsigned HIGH_W   = 8;

  localparam logic [START_W-1:0]  START_LOW_RST = 16'd18000;
  localparam logic [THRESH_W-1:0] THRESH_RST    = 8'd50;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_START_LOW     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_THRESHOLD = 1'd1;

  localparam int unsigned OUT_DATA_W = 48;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_START    = 3'd1,
    PH_WAIT_ACK = 3'd2,
    PH_ACK_LOW  = 3'd3,
    PH_ACK_HIGH = 3'd4,
    PH_BITS     = 3'd5
  } phase_e;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       frame_valid;
    logic [7:0] humidity_whole;
    logic [7:0] humidity_fraction;
    logic [7:0] temperature_whole;
    logic [7:0] temperature_fraction;
    logic [7:0] check_byte;
  } result_t;

  // byte k of the frame, first received byte first
  function automatic logic [7:0] frame_byte(logic [FRAME_BITS-1:0] frame, int unsigned k);
    logic [63:0] aligned;
    aligned = 64'(frame) << (64 - FRAME_BITS);
    return aligned[63 - 8*k -: 8];
  endfunction

endpackage

### rtl/swsfr_core.sv
// ----------------------------------------------------------------------------
// swsfr_core
// config registers, receive state machine and per-tick result logic
// ----------------------------------------------------------------------------
module swsfr_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [swsfr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [swsfr_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                                fire_i,
  input  logic                                action_i,
  input  logic                                pin_level_i,
  output swsfr_pkg::result_t                  result_o
);

  logic [swsfr_pkg::START_W-1:0]    start_low_q;
  logic [swsfr_pkg::THRESH_W-1:0]   thresh_q;

  swsfr_pkg::phase_e                phase_q, phase_d;
  logic [swsfr_pkg::START_W-1:0]    start_cnt_q, start_cnt_d;
  logic [swsfr_pkg::HIGH_W-1:0]     high_time_q, high_time_d;
  logic [swsfr_pkg::BITS_W-1:0]     bits_rx_q, bits_rx_d;
  logic [swsfr_pkg::FRAME_BITS-1:0] shift_q, shift_d;
  logic [swsfr_pkg::FRAME_BITS-1:0] frame_q, frame_d;
  logic                             prev_level_q, prev_level_d;

  logic                             drive;
  logic                             valid;
  logic [swsfr_pkg::START_W-1:0]    cnt_inc;
  logic [swsfr_pkg::BITS_W-1:0]     bits_inc;
  logic [swsfr_pkg::FRAME_BITS-1:0] shift_new;
  logic                             bit_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_low_q <= swsfr_pkg::START_LOW_RST;
      thresh_q    <= swsfr_pkg::THRESH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        swsfr_pkg::CFG_START_LOW:     start_low_q <= cfg_data_i;
        swsfr_pkg::CFG_ONE_THRESHOLD: thresh_q    <= cfg_data_i[swsfr_pkg::THRESH_W-1:0];
      endcase
    end
  end

  assign cnt_inc   = start_cnt_q + 1'b1;
  assign bits_inc  = bits_rx_q + 1'b1;
  assign bit_val   = (high_time_q > thresh_q);
  assign shift_new = {shift_q[swsfr_pkg::FRAME_BITS-2:0], bit_val};

  always_comb begin
    phase_d      = phase_q;
    start_cnt_d  = start_cnt_q;
    high_time_d  = high_time_q;
    bits_rx_d    = bits_rx_q;
    shift_d      = shift_q;
    frame_d      = frame_q;
    prev_level_d = prev_level_q;
    drive        = 1'b0;
    valid        = 1'b0;
    if (action_i) begin
      phase_d     = swsfr_pkg::PH_START;
      start_cnt_d = '0;
      high_time_d = '0;
      bits_rx_d   = '0;
      shift_d     = '0;
      drive       = 1'b1;
    end else begin
      prev_level_d = pin_level_i;
      unique case (phase_q)
        swsfr_pkg::PH_IDLE: begin
        end
        swsfr_pkg::PH_START: begin
          drive       = 1'b1;
          start_cnt_d = cnt_inc;
          if (cnt_inc >= start_low_q || cnt_inc == '0) begin
            phase_d = swsfr_pkg::PH_WAIT_ACK;
          end
        end
        swsfr_pkg::PH_WAIT_ACK: begin
          if (!pin_level_i) phase_d = swsfr_pkg::PH_ACK_LOW;
        end
        swsfr_pkg::PH_ACK_LOW: begin
          if (pin_level_i) phase_d = swsfr_pkg::PH_ACK_HIGH;
        end
        swsfr_pkg::PH_ACK_HIGH: begin
          if (!pin_level_i) begin
            phase_d     = swsfr_pkg::PH_BITS;
            high_time_d = '0;
          end
        end
        swsfr_pkg::PH_BITS: begin
          if (pin_level_i) begin
            if (high_time_q != '1) high_time_d = high_time_q + 1'b1;
          end else if (prev_level_q) begin
            shift_d     = shift_new;
            high_time_d = '0;
            bits_rx_d   = bits_inc;
            if (bits_inc >= swsfr_pkg::BITS_W'(swsfr_pkg::FRAME_BITS)) begin
              frame_d   = shift_new;
              valid     = 1'b1;
              phase_d   = swsfr_pkg::PH_IDLE;
              bits_rx_d = '0;
            end
          end
        end
        default: phase_d = swsfr_pkg::PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= swsfr_pkg::PH_IDLE;
      start_cnt_q  <= '0;
      high_time_q  <= '0;
      bits_rx_q    <= '0;
      shift_q      <= '0;
      frame_q      <= '0;
      prev_level_q <= 1'b1;
    end else if (fire_i) begin
      phase_q      <= phase_d;
      start_cnt_q  <= start_cnt_d;
      high_time_q  <= high_time_d;
      bits_rx_q    <= bits_rx_d;
      shift_q      <= shift_d;
      frame_q      <= frame_d;
      prev_level_q <= prev_level_d;
    end
  end

  always_comb begin
    result_o.drive_low            = drive;
    result_o.busy_res             = (phase_d != swsfr_pkg::PH_IDLE);
    result_o.frame_valid          = valid;
    result_o.humidity_whole       = swsfr_pkg::frame_byte(frame_d, 0);
    result_o.humidity_fraction    = swsfr_pkg::frame_byte(frame_d, 1);
    result_o.temperature_whole    = swsfr_pkg::frame_byte(frame_d, 2);
    result_o.temperature_fraction = swsfr_pkg::frame_byte(frame_d, 3);
    result_o.check_byte           = swsfr_pkg::frame_byte(frame_d, 4);
  end

endmodule

### rtl/swsfr_out_reg.sv
// ----------------------------------------------------------------------------
// swsfr_out_reg
// result register holding one beat for the output stream
// ----------------------------------------------------------------------------
module swsfr_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  swsfr_pkg::result_t   result_i,
  input  logic                 take_i,
  output logic                 valid_o,
  output swsfr_pkg::result_t   result_o
);

  logic               valid_q;
  swsfr_pkg::result_t result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) result_q <= result_i;
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

### rtl/single_wire_sensor_frame_receiver.sv
// ----------------------------------------------------------------------------
// single_wire_sensor_frame_receiver
// pulse-width receiver for a single-wire 40-bit humidity/temperature sensor
// ----------------------------------------------------------------------------
// each input beat is one microsecond tick with the sampled data pin, or a
// start request (tuser high). a start pulls the line low on its own beat and
// for start_low_ticks more ticks, then the block skips the sensor's response
// pulse and times every high pulse: longer than one_threshold_ticks decodes
// as 1. forty bits are shifted in msb first and published as five bytes with
// frame_valid (tlast) on the beat that completes the frame; the checksum is
// passed out unchecked. every accepted beat gives exactly one output beat,
// from a single result register; the block takes one beat per clock as long
// as the output side keeps taking results, since s_axis_tready is high
// whenever the result register is empty or is being read in the same cycle.
// config writes are taken at any time and must only be issued while idle.
// ----------------------------------------------------------------------------
module single_wire_sensor_frame_receiver (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // config write channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [swsfr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [swsfr_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [7:0]                           s_axis_tdata,  // [0] pin_level, rest zero
  input  logic                                 s_axis_tuser,  // [0] action
  // output stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [0] drive_low, [1] busy_res, [9:2] humidity_whole, [17:10] humidity_fraction,
  // [25:18] temperature_whole, [33:26] temperature_fraction, [41:34] check_byte
  output logic [swsfr_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                                 m_axis_tlast   // frame_valid
);

  logic               in_fire;
  logic               out_take;
  swsfr_pkg::result_t core_res;
  swsfr_pkg::result_t held_res;

  // config is always accepted
  assign cfg_ready_o = 1'b1;

  assign out_take      = m_axis_tvalid & m_axis_tready;
  // accept while the result register is free or drains this cycle
  assign s_axis_tready = ~m_axis_tvalid | m_axis_tready;
  assign in_fire       = s_axis_tvalid & s_axis_tready;

  swsfr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fire_i      (in_fire),
    .action_i    (s_axis_tuser),
    .pin_level_i (s_axis_tdata[0]),
    .result_o    (core_res)
  );

  swsfr_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (in_fire),
    .result_i (core_res),
    .take_i   (out_take),
    .valid_o  (m_axis_tvalid),
    .result_o (held_res)
  );

  assign m_axis_tdata = {6'd0,
                         held_res.check_byte,
                         held_res.temperature_fraction,
                         held_res.temperature_whole,
                         held_res.humidity_fraction,
                         held_res.humidity_whole,
                         held_res.busy_res,
                         held_res.drive_low};
  assign m_axis_tlast = held_res.frame_valid;

endmodule

### rtl/swsfr_checker.sv
// ----------------------------------------------------------------------------
// swsfr_checker
// port-level checks for the sensor frame receiver, bound to the top level
// ----------------------------------------------------------------------------
module swsfr_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             s_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [swsfr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tlast
);

  // a completed frame ends the reading
  a_frame_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> !m_axis_tdata[1])
    else $error("frame_valid with busy set");

  // the host only drives the line during a reading
  a_drive_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[1])
    else $error("drive_low outside a reading");

  // a start beat comes out next cycle with the line driven low
  a_start_drives: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=>
      m_axis_tvalid && m_axis_tdata[0] && !m_axis_tlast)
    else $error("start beat did not drive the line");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

endmodule

bind single_wire_sensor_frame_receiver swsfr_checker u_swsfr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

### tb/sv/single_wire_sensor_frame_receiver_tb.sv
// ----------------------------------------------------------------------------
// single_wire_sensor_frame_receiver_tb
// self-checking bench for the single-wire sensor frame receiver
// ----------------------------------------------------------------------------
// plays the sensor side of the line one tick per beat: start requests, the
// host low pulse, the response pulse and forty timed high pulses, mixed with
// cut-short readings, silent sensors and stray ticks. a local model of the
// receiver predicts one result per accepted beat and a monitor compares each
// output beat field by field. input bursts and output stalls are random, and
// the registers are swept through reset, extreme and random settings.
// ----------------------------------------------------------------------------
module single_wire_sensor_frame_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // a run is about 1.5k to 2.5k beats
  localparam int unsigned CYCLE_LIMIT    = 500_000;
  localparam int unsigned ITEMS_GOAL     = 1400;
  localparam int unsigned FRAMES_GOAL    = 2;
  localparam int unsigned SHOWN_MISMATCH = 10;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             cfg_valid_i;
  logic                             cfg_ready_o;
  logic [swsfr_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [swsfr_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  logic [7:0]                       s_axis_tdata;   // [0] pin_level, rest zero
  logic                             s_axis_tuser;   // [0] action
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  // [0] drive_low, [1] busy_res, [9:2] humidity_whole, [17:10] humidity_fraction,
  // [25:18] temperature_whole, [33:26] temperature_fraction, [41:34] check_byte
  logic [swsfr_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                             m_axis_tlast;   // frame_valid

  single_wire_sensor_frame_receiver dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // receiver model state and its copy of the registers
  swsfr_pkg::phase_e                ph_q;
  logic [swsfr_pkg::START_W-1:0]    start_cnt_q;
  logic [swsfr_pkg::HIGH_W-1:0]     high_q;
  int unsigned                      nbits_q;
  logic [swsfr_pkg::FRAME_BITS-1:0] shreg_q;
  logic [swsfr_pkg::FRAME_BITS-1:0] frame_q;
  logic                             prev_lvl_q;
  logic [swsfr_pkg::START_W-1:0]    start_low_q;
  logic [swsfr_pkg::THRESH_W-1:0]   thresh_q;

  swsfr_pkg::result_t pending_results[$];
  int unsigned        mismatches;
  int unsigned        burst_left;
  int unsigned        sent_beats;
  int unsigned        frames_done;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("single_wire_sensor_frame_receiver_tb: errors");
    $finish;
  end

  // output side stalls on a rotating pattern, reloaded now and then;
  // an all-ones pattern gives stretches with no backpressure
  initial begin : output_stalls
    logic [15:0] pattern;
    int unsigned left;
    m_axis_tready = 1'b0;
    pattern = '1;
    left = 0;
    forever begin
      @(posedge clk_i);
      if (left == 0) begin
        left = $urandom_range(64, 512);
        case ($urandom_range(0, 2))
          0: pattern = '1;
          1: pattern = 16'($urandom()) | 16'h0101;
          default: pattern = (16'($urandom()) & 16'($urandom())) | 16'h8000;
        endcase
      end
      left--;
      pattern = {pattern[14:0], pattern[15]};
      m_axis_tready <= pattern[0];
    end
  end

  // advance the receiver model by one accepted beat
  task automatic sensor_tick(input logic act, input logic lvl, output swsfr_pkg::result_t res);
    logic [63:0] aligned;
    logic        drive;
    logic        done;
    drive = 1'b0;
    done  = 1'b0;
    if (act) begin
      // a start always wins, even in the middle of a reading
      ph_q        = swsfr_pkg::PH_START;
      start_cnt_q = '0;
      high_q      = '0;
      nbits_q     = 0;
      shreg_q     = '0;
      drive       = 1'b1;
    end else begin
      case (ph_q)
        swsfr_pkg::PH_START: begin
          drive = 1'b1;
          start_cnt_q = start_cnt_q + 1'b1;
          // a zero length still gives one tick of low drive
          if (start_cnt_q >= start_low_q || start_cnt_q == '0) ph_q = swsfr_pkg::PH_WAIT_ACK;
        end
        swsfr_pkg::PH_WAIT_ACK: begin
          if (!lvl) ph_q = swsfr_pkg::PH_ACK_LOW;
        end
        swsfr_pkg::PH_ACK_LOW: begin
          if (lvl) ph_q = swsfr_pkg::PH_ACK_HIGH;
        end
        swsfr_pkg::PH_ACK_HIGH: begin
          // falling edge after the response pulse opens the first bit
          if (!lvl) begin
            ph_q   = swsfr_pkg::PH_BITS;
            high_q = '0;
          end
        end
        swsfr_pkg::PH_BITS: begin
          if (lvl) begin
            if (high_q != '1) high_q = high_q + 1'b1;
          end else if (prev_lvl_q) begin
            shreg_q = {shreg_q[swsfr_pkg::FRAME_BITS-2:0], (high_q > thresh_q)};
            high_q  = '0;
            nbits_q++;
            if (nbits_q >= swsfr_pkg::FRAME_BITS) begin
              frame_q = shreg_q;
              done    = 1'b1;
              ph_q    = swsfr_pkg::PH_IDLE;
              nbits_q = 0;
            end
          end
        end
        default: ph_q = swsfr_pkg::PH_IDLE;
      endcase
      prev_lvl_q = lvl;
    end
    aligned = 64'(frame_q) << (64 - swsfr_pkg::FRAME_BITS);
    res.drive_low            = drive;
    res.busy_res             = (ph_q != swsfr_pkg::PH_IDLE);
    res.frame_valid          = done;
    res.humidity_whole       = aligned[63:56];
    res.humidity_fraction    = aligned[55:48];
    res.temperature_whole    = aligned[47:40];
    res.temperature_fraction = aligned[39:32];
    res.check_byte           = aligned[31:24];
    if (done) frames_done++;
  endtask

  // one input beat; bursts of random length with random gaps between them
  task automatic send_tick(input logic act, input logic lvl);
    swsfr_pkg::result_t res;
    int unsigned        gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, lvl};
    s_axis_tuser  <= act;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_beats++;
    sensor_tick(act, lvl, res);
    pending_results.push_back(res);
  endtask

  // register write, only once every result in flight has come out
  task automatic write_reg(input logic [swsfr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [swsfr_pkg::CFG_DATA_W-1:0] val);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      swsfr_pkg::CFG_START_LOW:     start_low_q = val;
      swsfr_pkg::CFG_ONE_THRESHOLD: thresh_q = val[swsfr_pkg::THRESH_W-1:0];
      default: ;
    endcase
  endtask

  // threshold goes in the low byte; the upper byte is junk the block drops
  task automatic set_timing(input logic [swsfr_pkg::START_W-1:0] start_low,
                            input logic [7:0] thresh);
    write_reg(swsfr_pkg::CFG_START_LOW, start_low);
    write_reg(swsfr_pkg::CFG_ONE_THRESHOLD, {8'($urandom()), thresh});
  endtask

  // a sensor reading: start, host low pulse, pull-up, response pulse, then
  // nbits data bits; a cut start stops somewhere early in the host low pulse
  task automatic run_reading(input logic [swsfr_pkg::FRAME_BITS-1:0] payload,
                             input int unsigned nbits, input bit cut_start);
    int unsigned hold;
    int unsigned len;
    send_tick(1'b1, 1'($urandom_range(0, 1)));
    hold = (start_low_q == 0) ? 1 : start_low_q;
    if (cut_start) hold = $urandom_range(0, (hold > 16) ? 15 : hold - 1);
    // line reads low while pulled, with an odd glitch
    repeat (hold) send_tick(1'b0, 1'($urandom_range(0, 15) == 0));
    if (cut_start) return;
    repeat ($urandom_range(0, 3)) send_tick(1'b0, 1'b1);
    repeat ($urandom_range(1, 4)) send_tick(1'b0, 1'b0);
    repeat ($urandom_range(1, 4)) send_tick(1'b0, 1'b1);
    for (int unsigned b = 0; b < nbits; b++) begin
      repeat ($urandom_range(1, 2)) send_tick(1'b0, 1'b0);
      if (payload[swsfr_pkg::FRAME_BITS-1-b]) begin
        len = thresh_q + $urandom_range(1, 3);
      end else if (thresh_q == 0) begin
        len = 1;
      end else begin
        // a pulse of exactly the threshold still decodes as zero
        len = ($urandom_range(0, 1) == 0) ? thresh_q
                                          : $urandom_range(1, (thresh_q < 4) ? thresh_q : 4);
      end
      repeat (len) send_tick(1'b0, 1'b1);
    end
    if (nbits == swsfr_pkg::FRAME_BITS) begin
      repeat ($urandom_range(1, 3)) send_tick(1'b0, 1'b0);
      repeat ($urandom_range(1, 2)) send_tick(1'b0, 1'b1);
    end
  endtask

  // mostly complete readings, the rest noise and broken sequences
  task automatic run_mixed_traffic(input int unsigned rounds);
    logic [swsfr_pkg::FRAME_BITS-1:0] payload;
    int unsigned                      hold;
    for (int unsigned r = 0; r < rounds; r++) begin
      payload = swsfr_pkg::FRAME_BITS'({$urandom(), $urandom()});
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 12)) send_tick(1'b0, 1'($urandom_range(0, 1)));
        1: run_reading(payload, $urandom_range(0, swsfr_pkg::FRAME_BITS - 1), 1'b0);
        2: run_reading(payload, 0, 1'b1);
        3: begin
          // silent sensor: the line just stays high after release
          send_tick(1'b1, 1'b0);
          hold = (start_low_q == 0) ? 1 : start_low_q;
          repeat (hold) send_tick(1'b0, 1'b0);
          repeat ($urandom_range(5, 20)) send_tick(1'b0, 1'b1);
        end
        default: run_reading(payload, swsfr_pkg::FRAME_BITS, 1'b0);
      endcase
    end
  endtask

  function automatic string show(swsfr_pkg::result_t r);
    return $sformatf("drive=%0b busy=%0b frame=%0b bytes=%h %h %h %h %h",
                     r.drive_low, r.busy_res, r.frame_valid, r.humidity_whole,
                     r.humidity_fraction, r.temperature_whole, r.temperature_fraction,
                     r.check_byte);
  endfunction

  function automatic void flag(string msg);
    mismatches++;
    if (mismatches <= SHOWN_MISMATCH) $display("%s", msg);
  endfunction

  // compare every output beat with the oldest prediction
  always @(posedge clk_i) begin : result_check
    swsfr_pkg::result_t seen;
    swsfr_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen.drive_low            = m_axis_tdata[0];
      seen.busy_res             = m_axis_tdata[1];
      seen.frame_valid          = m_axis_tlast;
      seen.humidity_whole       = m_axis_tdata[9:2];
      seen.humidity_fraction    = m_axis_tdata[17:10];
      seen.temperature_whole    = m_axis_tdata[25:18];
      seen.temperature_fraction = m_axis_tdata[33:26];
      seen.check_byte           = m_axis_tdata[41:34];
      if (pending_results.size() == 0) begin
        flag($sformatf("%0t: output beat with nothing expected: %s", $realtime, show(seen)));
      end else begin
        want = pending_results.pop_front();
        if (seen !== want)
          flag($sformatf("%0t: mismatch\n  expected %s\n  actual   %s",
                         $realtime, show(want), show(seen)));
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_idle_ticks();
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
  endtask

  // start while already busy restarts the low pulse
  task automatic test_start_restart();
    send_tick(1'b1, 1'b1);
    repeat (3) send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    repeat (2) send_tick(1'b0, 1'b1);
  endtask

  // reset values: the low pulse is still held after a dozen ticks, then a
  // short reading decodes against the reset threshold
  task automatic test_reset_config_reading();
    send_tick(1'b1, 1'b0);
    repeat (12) send_tick(1'b0, 1'b0);
    write_reg(swsfr_pkg::CFG_START_LOW, 16'd2);
    run_reading(40'hA5_00_00_00_00, 6, 1'b0);
  endtask

  task automatic test_start_length_zero();
    set_timing(16'd0, 8'd2);
    send_tick(1'b1, 1'b0);
    repeat (3) send_tick(1'b0, 1'b0);
  endtask

  task automatic test_silent_sensor();
    set_timing(16'd1, 8'd2);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    repeat (6) send_tick(1'b0, 1'b1);
  endtask

  task automatic test_extreme_settings();
    set_timing(16'hFFFF, 8'hFF);
    send_tick(1'b1, 1'b1);
    repeat (16) send_tick(1'b0, 1'b0);
    set_timing(16'd1, 8'd1);
    run_reading(40'h00_FF_00_FF_00, swsfr_pkg::FRAME_BITS, 1'b0);
  endtask

  // a high pulse past 255 ticks pins the counter instead of wrapping
  task automatic test_long_pulse();
    set_timing(16'd1, 8'd3);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    repeat (257) send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    repeat (2) send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
  endtask

  task automatic test_threshold_zero();
    set_timing(16'd0, 8'd0);
    run_mixed_traffic(2);
  endtask

  // random small timings keep frames short; goes on until the beat count
  // is reached and at least two frames have finished
  task automatic test_random_readings();
    int unsigned                   frame_base;
    logic [swsfr_pkg::START_W-1:0] start_low;
    logic [7:0]                    thresh;
    frame_base = frames_done;
    while (sent_beats < ITEMS_GOAL || frames_done - frame_base < FRAMES_GOAL) begin
      start_low = ($urandom_range(0, 7) == 0) ? 16'd0
                                              : swsfr_pkg::START_W'($urandom_range(1, 6));
      thresh    = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(5, 20))
                                              : 8'($urandom_range(0, 4));
      set_timing(start_low, thresh);
      run_mixed_traffic(2);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    mismatches    = 0;
    burst_left    = 0;
    sent_beats    = 0;
    frames_done   = 0;
    ph_q          = swsfr_pkg::PH_IDLE;
    start_cnt_q   = '0;
    high_q        = '0;
    nbits_q       = 0;
    shreg_q       = '0;
    frame_q       = '0;
    prev_lvl_q    = 1'b1;
    start_low_q   = swsfr_pkg::START_LOW_RST;
    thresh_q      = swsfr_pkg::THRESH_RST;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_ticks();
    test_start_restart();
    test_reset_config_reading();
    test_start_length_zero();
    test_silent_sensor();
    test_extreme_settings();
    test_long_pulse();
    test_threshold_zero();
    test_random_readings();

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    // a further wait catches any stray output beat
    repeat (8) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("single_wire_sensor_frame_receiver_tb: clean");
    end else begin
      $display("single_wire_sensor_frame_receiver_tb: errors");
    end
    $finish;
  end

endmodule
